FILE: design/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg: shared definitions for the box affine transform
// Widths, register map codes, reset values and the stage enable bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

  // Number formats: coordinates Q16.16, coefficients Q4.12.
  localparam int COORD_W     = 32;
  localparam int COEF_W      = 16;
  localparam int COEF_STRIDE = 16;
  localparam int FRAC_W      = 12;
  localparam int NUM_AXES    = 3;
  localparam int ROW_W       = NUM_AXES * COEF_STRIDE;
  localparam int PROD_W      = COORD_W + COEF_W;
  // Three products plus the translation need two guard bits.
  localparam int ACC_W       = PROD_W + 2;

  // Stream payload: three minimum coordinates, then three maximum coordinates.
  localparam int BOX_W       = 2 * NUM_AXES * COORD_W;

  // Configuration port.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  // Reset to the identity transform: 1.0 on the diagonal, no translation.
  localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(48'h0000_0000_1000);
  localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(48'h0000_1000_0000);
  localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(48'h1000_0000_0000);

  // Load strobes for the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

FILE: design/aat_axis.sv
// ----------------------------------------------------------------------------
// aat_axis: bounds of one output axis
// Four-stage datapath that returns the minimum and maximum of one row of the
// affine map over the eight corners of a box.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_axis import aat_pkg::*; (
  input  wire                       clk,
  input  stage_en_t                 en,
  input  wire [ROW_W-1:0]           row,      // coefficient x, y, z from bit 0 up
  input  wire signed [COORD_W-1:0]  shift,
  input  wire [NUM_AXES*COORD_W-1:0] lo,      // lo_x, lo_y, lo_z from bit 0 up
  input  wire [NUM_AXES*COORD_W-1:0] hi,      // hi_x, hi_y, hi_z from bit 0 up
  output logic signed [COORD_W-1:0] res_lo,
  output logic signed [COORD_W-1:0] res_hi
);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [COEF_W-1:0]  cf   [NUM_AXES];
  logic signed [COORD_W-1:0] lo_c [NUM_AXES];
  logic signed [COORD_W-1:0] hi_c [NUM_AXES];

  logic signed [PROD_W-1:0]  p_lo [NUM_AXES];
  logic signed [PROD_W-1:0]  p_hi [NUM_AXES];
  logic signed [PROD_W-1:0]  t_min [NUM_AXES];
  logic signed [PROD_W-1:0]  t_max [NUM_AXES];
  logic signed [ACC_W-1:0]   acc_min;
  logic signed [ACC_W-1:0]   acc_max;
  logic signed [ACC_W-1:0]   acc_min_next;
  logic signed [ACC_W-1:0]   acc_max_next;

  // Saturate a shifted sum to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] v;
    v = acc >>> FRAC_W;
    if (v > SAT_MAX) begin
      return SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  // Split the packed operands into per-axis signed values.
  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      cf[c]   = row[c*COEF_STRIDE +: COEF_W];
      lo_c[c] = lo[c*COORD_W +: COORD_W];
      hi_c[c] = hi[c*COORD_W +: COORD_W];
    end
  end

  // Stage 1: each coefficient times both ends of its input interval.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        p_lo[c] <= cf[c] * lo_c[c];
        p_hi[c] <= cf[c] * hi_c[c];
      end
    end
  end

  // Stage 2: every term picks its end independently, so the corner extremes
  // are the sums of the per-term extremes.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        if (p_lo[c] < p_hi[c]) begin
          t_min[c] <= p_lo[c];
          t_max[c] <= p_hi[c];
        end else begin
          t_min[c] <= p_hi[c];
          t_max[c] <= p_lo[c];
        end
      end
    end
  end

  // Stage 3: exact sums with the translation aligned to the product scale.
  always_comb begin
    acc_min_next = ACC_W'(shift) <<< FRAC_W;
    acc_max_next = ACC_W'(shift) <<< FRAC_W;
    for (int c = 0; c < NUM_AXES; c++) begin
      acc_min_next = acc_min_next + ACC_W'(t_min[c]);
      acc_max_next = acc_max_next + ACC_W'(t_max[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      acc_min <= acc_min_next;
      acc_max <= acc_max_next;
    end
  end

  // Stage 4: rescale and saturate; both steps keep the order of values.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_lo <= sat_coord(acc_min);
      res_hi <= sat_coord(acc_max);
    end
  end

endmodule

`default_nettype wire

FILE: design/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform: affine transform of an axis-aligned box
// Streams boxes through a 3x3 linear map plus translation and returns the
// bounds of the transformed corners; empty boxes pass through flagged.
// ----------------------------------------------------------------------------
// Flow: each box moves through the multiply, compare, sum and saturate stage
// registers in order, each stage holding one box.
// Throughput: one box per cycle while the output is not stalled; a stall
// only fills bubbles ahead of it.
// Reset: synchronous; clears all stage valid bits and loads the identity
// transform into the configuration registers.
`default_nettype none

module aabb_affine_transform import aat_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  // Input boxes.
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire [BOX_W-1:0]       s_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  // Output boxes.
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [BOX_W-1:0]      m_tdata,   // new_lo_x, new_lo_y, new_lo_z,
                                           // new_hi_x, new_hi_y, new_hi_z
  output logic [0:0]            m_tuser,   // box_empty
  // Configuration.
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [CFG_ADDR_W-1:0]  paddr,
  input  wire [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int HALF_W = NUM_AXES * COORD_W;

  logic [ROW_W-1:0]          row_reg   [NUM_AXES];
  logic signed [COORD_W-1:0] shift_reg [NUM_AXES];

  logic                      cfg_wr;
  cfg_reg_t                  cfg_idx;

  logic                      v1, v2, v3, v4;
  logic                      rdy1, rdy2, rdy3, rdy4;
  stage_en_t                 en;

  logic                      empty_in;
  logic                      e1, e2, e3, e4;
  logic [BOX_W-1:0]          pass1, pass2, pass3, pass4;

  logic signed [COORD_W-1:0] res_lo [NUM_AXES];
  logic signed [COORD_W-1:0] res_hi [NUM_AXES];

  // Configuration registers; writes to unused indexes are dropped.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1 -: REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg[0]   <= ROW_X_RESET;
      row_reg[1]   <= ROW_Y_RESET;
      row_reg[2]   <= ROW_Z_RESET;
      shift_reg[0] <= '0;
      shift_reg[1] <= '0;
      shift_reg[2] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_X:   row_reg[0]   <= pwdata[ROW_W-1:0];
        REG_ROW_Y:   row_reg[1]   <= pwdata[ROW_W-1:0];
        REG_ROW_Z:   row_reg[2]   <= pwdata[ROW_W-1:0];
        REG_SHIFT_X: shift_reg[0] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y: shift_reg[1] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z: shift_reg[2] <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_ROW_X:   prdata = CFG_DATA_W'(row_reg[0]);
      REG_ROW_Y:   prdata = CFG_DATA_W'(row_reg[1]);
      REG_ROW_Z:   prdata = CFG_DATA_W'(row_reg[2]);
      REG_SHIFT_X: prdata = CFG_DATA_W'(unsigned'(shift_reg[0]));
      REG_SHIFT_Y: prdata = CFG_DATA_W'(unsigned'(shift_reg[1]));
      REG_SHIFT_Z: prdata = CFG_DATA_W'(unsigned'(shift_reg[2]));
      default:     prdata = '0;
    endcase
  end

  // Pipeline flow: a stage loads when it is empty or its successor moves.
  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // A box is empty when any minimum exceeds its maximum.
  always_comb begin
    empty_in = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($signed(s_tdata[a*COORD_W +: COORD_W]) >
          $signed(s_tdata[HALF_W + a*COORD_W +: COORD_W])) begin
        empty_in = 1'b1;
      end
    end
  end

  // Empty flag and the original box travel beside the datapath.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      e1    <= empty_in;
      pass1 <= s_tdata;
    end
    if (en.s2) begin
      e2    <= e1;
      pass2 <= pass1;
    end
    if (en.s3) begin
      e3    <= e2;
      pass3 <= pass2;
    end
    if (en.s4) begin
      e4    <= e3;
      pass4 <= pass3;
    end
  end

  // One datapath per output axis.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    aat_axis u_axis (
      .clk    (clk),
      .en     (en),
      .row    (row_reg[a]),
      .shift  (shift_reg[a]),
      .lo     (s_tdata[HALF_W-1:0]),
      .hi     (s_tdata[BOX_W-1:HALF_W]),
      .res_lo (res_lo[a]),
      .res_hi (res_hi[a])
    );
  end

  // Output selection: empty boxes return unchanged.
  assign m_tvalid   = v4;
  assign m_tuser[0] = e4;

  always_comb begin
    if (e4) begin
      m_tdata = pass4;
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        m_tdata[a*COORD_W +: COORD_W]          = res_lo[a];
        m_tdata[HALF_W + a*COORD_W +: COORD_W] = res_hi[a];
      end
    end
  end

`ifndef SYNTH
  // Input ready low means every stage holds a box.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4))
    else $error("input blocked while the pipeline has a free stage");

  // A stalled output keeps the box behind it in place.
  a_stall_holds_stage3: assert property (@(posedge clk) disable iff (rst)
    (v4 && !m_tready && v3) |=> v3)
    else $error("stage three box lost during an output stall");

  // An accepted box always occupies the first stage next cycle.
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted box did not enter the pipeline");

  // A transformed box never has a minimum above its maximum.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (v4 && !e4) |-> (res_lo[0] <= res_hi[0] && res_lo[1] <= res_hi[1] &&
                     res_lo[2] <= res_hi[2]))
    else $error("transformed bounds out of order");
`endif

endmodule

`default_nettype wire
